@@ hdl/pcnr_pkg.sv @@
`default_nettype none

package pcnr_pkg;

  localparam int unsigned MAX_HEIGHT_DEF = 4096;
  localparam int unsigned SLOT_WIDTH_DEF = 20;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SC_W       = 16;
  localparam int unsigned CH_W       = 13;
  localparam int unsigned IC_W       = 8;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ROW_W  = 13;
  localparam int unsigned VOL_W  = 9;
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned PROD_W = 25;

  // Record bits other than the slot: kind, row/count, two channels, blue, alpha, sample.
  localparam int unsigned REC_FIXED_W = 1 + ROW_W + 2 * (VOL_W + BYTE_W + VOL_W)
                                        + 2 * BYTE_W + SMP_W;
  localparam int unsigned QUEUE_DEPTH = 8;

  // ceil(2^32 / 255): floor(x * RECIP_255 / 2^32) == floor(x / 255) for x < 2^24.
  localparam logic [PROD_W-1:0] RECIP_255 = 25'h101_0102;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT     = 2'd0,
    CFG_COLUMN_HEIGHT    = 2'd1,
    CFG_INSTRUMENT_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_NOTE   = 1'b0,
    KIND_HEADER = 1'b1
  } rec_kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] cur_left;
    logic [BYTE_W-1:0] cur_right;
    logic [BYTE_W-1:0] cur_blue;
    logic [BYTE_W-1:0] cur_alpha;
    logic [BYTE_W-1:0] prev_left;
    logic [BYTE_W-1:0] prev_right;
    logic [BYTE_W-1:0] prev_blue;
    logic [BYTE_W-1:0] prev_alpha;
  } pixel_t;

  typedef struct packed {
    logic             note_en;
    logic             hdr_en;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] count;
  } pix_ctl_t;

endpackage

`default_nettype wire

@@ hdl/pcnr_if.sv @@
`default_nettype none

interface pcnr_in_if;
  logic                          valid;
  logic                          ready;
  logic [pcnr_pkg::BYTE_W-1:0]   cur_left;
  logic [pcnr_pkg::BYTE_W-1:0]   cur_right;
  logic [pcnr_pkg::BYTE_W-1:0]   cur_blue;
  logic [pcnr_pkg::BYTE_W-1:0]   cur_alpha;
  logic [pcnr_pkg::BYTE_W-1:0]   prev_left;
  logic [pcnr_pkg::BYTE_W-1:0]   prev_right;
  logic [pcnr_pkg::BYTE_W-1:0]   prev_blue;
  logic [pcnr_pkg::BYTE_W-1:0]   prev_alpha;

  modport source (
    output valid, cur_left, cur_right, cur_blue, cur_alpha,
           prev_left, prev_right, prev_blue, prev_alpha,
    input  ready
  );
  modport sink (
    input  valid, cur_left, cur_right, cur_blue, cur_alpha,
           prev_left, prev_right, prev_blue, prev_alpha,
    output ready
  );
endinterface

interface pcnr_out_if #(
  parameter int unsigned SlotW = pcnr_pkg::SLOT_WIDTH_DEF
);
  logic                               valid;
  logic                               ready;
  logic                               record_kind;
  logic [SlotW-1:0]                   slot;
  logic [pcnr_pkg::ROW_W-1:0]         row_or_count;
  logic signed [pcnr_pkg::VOL_W-1:0]  vol_left;
  logic [pcnr_pkg::BYTE_W-1:0]        prev_vol_left;
  logic signed [pcnr_pkg::VOL_W-1:0]  diff_left;
  logic signed [pcnr_pkg::VOL_W-1:0]  vol_right;
  logic [pcnr_pkg::BYTE_W-1:0]        prev_vol_right;
  logic signed [pcnr_pkg::VOL_W-1:0]  diff_right;
  logic [pcnr_pkg::BYTE_W-1:0]        blue_out;
  logic [pcnr_pkg::BYTE_W-1:0]        alpha_out;
  logic [pcnr_pkg::SMP_W-1:0]         sample_index;

  modport source (
    output valid, record_kind, slot, row_or_count, vol_left, prev_vol_left, diff_left,
           vol_right, prev_vol_right, diff_right, blue_out, alpha_out, sample_index,
    input  ready
  );
  modport sink (
    input  valid, record_kind, slot, row_or_count, vol_left, prev_vol_left, diff_left,
           vol_right, prev_vol_right, diff_right, blue_out, alpha_out, sample_index,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/pcnr_ctrl.sv @@
`default_nettype none

module pcnr_ctrl #(
  parameter int unsigned MAX_HEIGHT = pcnr_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned SLOT_WIDTH = pcnr_pkg::SLOT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pcnr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcnr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            fire_i,
  input  pcnr_pkg::pixel_t                pix_i,
  output pcnr_pkg::pix_ctl_t              ctl_o,
  output logic [SLOT_WIDTH-1:0]           note_slot_o,
  output logic [SLOT_WIDTH-1:0]           hdr_slot_o,
  output logic [pcnr_pkg::SC_W-1:0]       sample_count_o
);
  import pcnr_pkg::*;

  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned HW = RW + 1;

  // Clamp the height register into 1..MAX_HEIGHT.
  function automatic logic [HW-1:0] eff_h(input logic [CH_W-1:0] ch);
    logic [31:0] v;
    v = 32'(ch);
    if (v == 32'd0) v = 32'd1;
    if (v > MAX_HEIGHT) v = MAX_HEIGHT;
    return HW'(v);
  endfunction

  logic [SC_W-1:0]       sc_q, sc_d;
  logic [CH_W-1:0]       ch_q, ch_d;
  logic [IC_W-1:0]       ic_q, ic_d;
  logic [RW-1:0]         row_q, row_d;
  logic [RW-1:0]         pix_q, pix_d;
  logic [SLOT_WIDTH-1:0] next_q, next_d;
  logic [SLOT_WIDTH-1:0] hdr_q, hdr_d;
  logic [ROW_W-1:0]      osc_q, osc_d;
  logic [IC_W-1:0]       col_q, col_d;

  logic                  note;
  logic [HW-1:0]         h;
  logic [HW-1:0]         h_new;
  logic [IC_W-1:0]       inst;
  logic                  col_end;
  logic                  last;
  logic [SLOT_WIDTH-1:0] ns1;
  logic [ROW_W-1:0]      osc1;

  always_comb begin
    note    = |{pix_i.cur_left, pix_i.prev_left, pix_i.cur_right, pix_i.prev_right};
    h       = eff_h(ch_q);
    h_new   = eff_h(cfg_wdata_i[CH_W-1:0]);
    inst    = (ic_q == '0) ? IC_W'(1) : ic_q;
    last    = ({1'b0, pix_q} + HW'(1)) >= h;
    col_end = ({1'b0, col_q} + (IC_W + 1)'(1)) >= {1'b0, inst};
    ns1     = next_q + SLOT_WIDTH'(note);
    osc1    = osc_q + ROW_W'(note);

    sc_d   = sc_q;
    ch_d   = ch_q;
    ic_d   = ic_q;
    row_d  = row_q;
    pix_d  = pix_q;
    next_d = next_q;
    hdr_d  = hdr_q;
    osc_d  = osc_q;
    col_d  = col_q;

    if (fire_i) begin
      if (last) begin
        pix_d = '0;
        osc_d = '0;
        row_d = RW'(h - HW'(1));
        if (col_end) begin
          col_d  = '0;
          hdr_d  = '0;
          next_d = SLOT_WIDTH'(1);
        end else begin
          col_d  = col_q + IC_W'(1);
          hdr_d  = ns1;
          next_d = ns1 + SLOT_WIDTH'(1);
        end
      end else begin
        pix_d  = pix_q + RW'(1);
        osc_d  = osc1;
        next_d = ns1;
        // stop at row zero when the height was lowered mid-column
        row_d  = (row_q != '0) ? row_q - RW'(1) : row_q;
      end
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SAMPLE_COUNT: sc_d = cfg_wdata_i[SC_W-1:0];
        CFG_COLUMN_HEIGHT: begin
          ch_d = cfg_wdata_i[CH_W-1:0];
          if (pix_q == '0) row_d = RW'(h_new - HW'(1));
        end
        CFG_INSTRUMENT_COUNT: ic_d = cfg_wdata_i[IC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q   <= '0;
      ch_q   <= CH_W'(1);
      ic_q   <= IC_W'(1);
      row_q  <= '0;
      pix_q  <= '0;
      next_q <= SLOT_WIDTH'(1);
      hdr_q  <= '0;
      osc_q  <= '0;
      col_q  <= '0;
    end else begin
      sc_q   <= sc_d;
      ch_q   <= ch_d;
      ic_q   <= ic_d;
      row_q  <= row_d;
      pix_q  <= pix_d;
      next_q <= next_d;
      hdr_q  <= hdr_d;
      osc_q  <= osc_d;
      col_q  <= col_d;
    end
  end

  assign ctl_o.note_en  = note;
  assign ctl_o.hdr_en   = last;
  assign ctl_o.row      = ROW_W'(row_q);
  assign ctl_o.count    = osc1;
  assign note_slot_o    = next_q;
  assign hdr_slot_o     = hdr_q;
  assign sample_count_o = sc_q;

endmodule

`default_nettype wire

@@ hdl/pcnr_calc.sv @@
`default_nettype none

module pcnr_calc #(
  parameter int unsigned SLOT_WIDTH = pcnr_pkg::SLOT_WIDTH_DEF,
  parameter int unsigned REC_W      = pcnr_pkg::REC_FIXED_W + SLOT_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  pcnr_pkg::pixel_t          pix_i,
  input  pcnr_pkg::pix_ctl_t        ctl_i,
  input  logic [SLOT_WIDTH-1:0]     note_slot_i,
  input  logic [SLOT_WIDTH-1:0]     hdr_slot_i,
  input  logic [pcnr_pkg::SC_W-1:0] sample_count_i,
  output logic [1:0]                inflight_o,
  output logic                      wr_a_o,
  output logic [REC_W-1:0]          rec_a_o,
  output logic                      wr_b_o,
  output logic [REC_W-1:0]          rec_b_o
);
  import pcnr_pkg::*;

  typedef struct packed {
    logic [VOL_W-1:0]  vol;
    logic [BYTE_W-1:0] pv;
    logic [VOL_W-1:0]  diff;
    logic              off;
  } chan_t;

  function automatic chan_t chan_f(input logic [BYTE_W-1:0] c, input logic [BYTE_W-1:0] p);
    chan_t r;
    if (c != '0) begin
      r.vol  = {1'b0, c};
      r.pv   = p;
      r.diff = {1'b0, c} - {1'b0, p};
      r.off  = 1'b0;
    end else if (p != '0) begin
      r.vol  = '0;
      r.pv   = p;
      r.diff = -{1'b0, p};
      r.off  = 1'b1;
    end else begin
      r.vol  = '1;
      r.pv   = '0;
      r.diff = '0;
      r.off  = 1'b0;
    end
    return r;
  endfunction

  // Stage 1: registered pixel and its slot/row decisions.
  logic                  v1_q;
  pixel_t                pix1_q;
  pix_ctl_t              ctl1_q;
  logic [SLOT_WIDTH-1:0] nslot1_q, hslot1_q;
  logic [SC_W-1:0]       sc1_q;

  // Stage 2: channel results and the blue * (S + 1) product.
  logic                  v2_q;
  pix_ctl_t              ctl2_q;
  logic [SLOT_WIDTH-1:0] nslot2_q, hslot2_q;
  chan_t                 chl2_q, chr2_q, chl_d, chr_d;
  logic [BYTE_W-1:0]     blue2_q, alpha2_q, blue_d, alpha_d;
  logic                  bmax2_q;
  logic [PROD_W-1:0]     prod2_q, prod_d;

  logic [2*PROD_W-1:0]   quot_full;
  logic [SMP_W-1:0]      smp;

  always_comb begin
    chl_d   = chan_f(pix1_q.cur_left, pix1_q.prev_left);
    chr_d   = chan_f(pix1_q.cur_right, pix1_q.prev_right);
    blue_d  = (chl_d.off | chr_d.off) ? pix1_q.prev_blue  : pix1_q.cur_blue;
    alpha_d = (chl_d.off | chr_d.off) ? pix1_q.prev_alpha : pix1_q.cur_alpha;
    prod_d  = PROD_W'(blue_d) * (PROD_W'(sc1_q) + PROD_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= fire_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix1_q   <= pix_i;
    ctl1_q   <= ctl_i;
    nslot1_q <= note_slot_i;
    hslot1_q <= hdr_slot_i;
    sc1_q    <= sample_count_i;

    ctl2_q   <= ctl1_q;
    nslot2_q <= nslot1_q;
    hslot2_q <= hslot1_q;
    chl2_q   <= chl_d;
    chr2_q   <= chr_d;
    blue2_q  <= blue_d;
    alpha2_q <= alpha_d;
    bmax2_q  <= (blue_d == '1);
    prod2_q  <= prod_d;
  end

  // divide by 255 through the reciprocal; blue at full scale maps to zero
  assign quot_full = (2*PROD_W)'(prod2_q) * (2*PROD_W)'(RECIP_255);
  assign smp       = bmax2_q ? '0 : quot_full[32 +: SMP_W];

  assign rec_a_o = {KIND_NOTE, nslot2_q, ctl2_q.row,
                    chl2_q.vol, chl2_q.pv, chl2_q.diff,
                    chr2_q.vol, chr2_q.pv, chr2_q.diff,
                    blue2_q, alpha2_q, smp};
  assign rec_b_o = {KIND_HEADER, hslot2_q, ctl2_q.count,
                    (REC_FIXED_W - 1 - ROW_W)'(0)};

  assign wr_a_o     = v2_q & ctl2_q.note_en;
  assign wr_b_o     = v2_q & ctl2_q.hdr_en;
  assign inflight_o = 2'(v1_q) + 2'(v2_q);

endmodule

`default_nettype wire

@@ hdl/pcnr_queue.sv @@
`default_nettype none

module pcnr_queue #(
  parameter int unsigned WIDTH = pcnr_pkg::REC_FIXED_W + pcnr_pkg::SLOT_WIDTH_DEF,
  parameter int unsigned DEPTH = pcnr_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_a_i,
  input  logic [WIDTH-1:0]           data_a_i,
  input  logic                       wr_b_i,
  input  logic [WIDTH-1:0]           data_b_i,
  input  logic                       rd_i,
  output logic                       valid_o,
  output logic [WIDTH-1:0]           data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d, wp_b;
  logic [CW-1:0]    cnt_q, cnt_d;

  // second entry of a beat pair lands right behind the first
  assign wp_b = wp_q + AW'(wr_a_i);

  always_comb begin
    wp_d  = wp_q + AW'(wr_a_i) + AW'(wr_b_i);
    rp_d  = rp_q + AW'(rd_i);
    cnt_d = cnt_q + CW'(wr_a_i) + CW'(wr_b_i) - CW'(rd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a_i) mem_q[wp_q] <= data_a_i;
    if (wr_b_i) mem_q[wp_b] <= data_b_i;
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign count_o = cnt_q;

endmodule

`default_nettype wire

@@ hdl/pixel_column_to_note_records_top.sv @@
// Path: a pixel's records pass calc stage 1 and stage 2, then the record queue.
// Throughput: one pixel per cycle while input ready is high; a column's last pixel
//   may add a header record. Records leave an 8-entry record queue one per cycle
//   while out_if.ready is high.
// Input ready drops only when the queue plus the two in-flight stages could overflow.
// Reset (rst_ni, async, active low) restores register defaults, empties the queue.
`default_nettype none

module pixel_column_to_note_records_top #(
  parameter int unsigned MAX_HEIGHT = pcnr_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned SLOT_WIDTH = pcnr_pkg::SLOT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pcnr_in_if.sink                         in_if,
  pcnr_out_if.source                      out_if,
  input  logic                            cfg_we_i,
  input  logic [pcnr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcnr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import pcnr_pkg::*;

  localparam int unsigned REC_W = REC_FIXED_W + SLOT_WIDTH;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);

  logic                  in_fire;
  logic                  out_fire;
  pixel_t                pix;
  pix_ctl_t              ctl;
  logic [SLOT_WIDTH-1:0] note_slot, hdr_slot;
  logic [SC_W-1:0]       sample_count;
  logic [1:0]            inflight;
  logic                  wr_a, wr_b;
  logic [REC_W-1:0]      rec_a, rec_b, rec_out;
  logic [CW-1:0]         q_count;
  logic [CW+2:0]         reserved;

  // Gather the input beat into one pixel word.
  assign pix.cur_left   = in_if.cur_left;
  assign pix.cur_right  = in_if.cur_right;
  assign pix.cur_blue   = in_if.cur_blue;
  assign pix.cur_alpha  = in_if.cur_alpha;
  assign pix.prev_left  = in_if.prev_left;
  assign pix.prev_right = in_if.prev_right;
  assign pix.prev_blue  = in_if.prev_blue;
  assign pix.prev_alpha = in_if.prev_alpha;

  // Every pixel in flight may still turn into two records; hold off new beats
  // unless the queue has room for all of them plus the next one.
  assign reserved    = (CW + 3)'(q_count) + ((CW + 3)'(inflight) << 1);
  assign in_if.ready = reserved <= (CW + 3)'(QUEUE_DEPTH - 2);
  assign in_fire     = in_if.valid & in_if.ready;

  // Counters, slots and configuration registers; decisions made at accept.
  pcnr_ctrl #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .SLOT_WIDTH (SLOT_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fire_i         (in_fire),
    .pix_i          (pix),
    .ctl_o          (ctl),
    .note_slot_o    (note_slot),
    .hdr_slot_o     (hdr_slot),
    .sample_count_o (sample_count)
  );

  // Channel rules, color pick and sample index over two register stages.
  pcnr_calc #(
    .SLOT_WIDTH (SLOT_WIDTH),
    .REC_W      (REC_W)
  ) u_calc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (in_fire),
    .pix_i          (pix),
    .ctl_i          (ctl),
    .note_slot_i    (note_slot),
    .hdr_slot_i     (hdr_slot),
    .sample_count_i (sample_count),
    .inflight_o     (inflight),
    .wr_a_o         (wr_a),
    .rec_a_o        (rec_a),
    .wr_b_o         (wr_b),
    .rec_b_o        (rec_b)
  );

  // Note first, header after it, so a column's last pixel keeps its order.
  pcnr_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_a_i   (wr_a),
    .data_a_i (rec_a),
    .wr_b_i   (wr_b),
    .data_b_i (rec_b),
    .rd_i     (out_fire),
    .valid_o  (out_if.valid),
    .data_o   (rec_out),
    .count_o  (q_count)
  );

  assign out_fire = out_if.valid & out_if.ready;

  // Unpack the head record onto the output beat.
  assign {out_if.record_kind, out_if.slot, out_if.row_or_count,
          out_if.vol_left, out_if.prev_vol_left, out_if.diff_left,
          out_if.vol_right, out_if.prev_vol_right, out_if.diff_right,
          out_if.blue_out, out_if.alpha_out, out_if.sample_index} = rec_out;

endmodule

`default_nettype wire

@@ hdl/pcnr_checker.sv @@
`default_nettype none

module pcnr_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic                               record_kind_i,
  input  logic [pcnr_pkg::ROW_W-1:0]         row_or_count_i,
  input  logic [pcnr_pkg::VOL_W-1:0]         vol_left_i,
  input  logic [pcnr_pkg::BYTE_W-1:0]        prev_vol_left_i,
  input  logic [pcnr_pkg::VOL_W-1:0]         diff_left_i,
  input  logic [pcnr_pkg::VOL_W-1:0]         vol_right_i,
  input  logic [pcnr_pkg::VOL_W-1:0]         diff_right_i,
  input  logic [pcnr_pkg::SMP_W-1:0]         sample_index_i
);
  import pcnr_pkg::*;

  logic note_beat;
  assign note_beat = out_valid_i && (record_kind_i == KIND_NOTE);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(record_kind_i)
      && $stable(row_or_count_i) && $stable(sample_index_i))
    else $error("record changed while stalled");

  a_header_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (record_kind_i == KIND_HEADER) |->
      vol_left_i == '0 && vol_right_i == '0 && diff_left_i == '0
      && diff_right_i == '0 && sample_index_i == '0)
    else $error("header record carries note fields");

  a_dark_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_beat && (vol_left_i == '1) |-> prev_vol_left_i == '0 && diff_left_i == '0)
    else $error("dark left channel with nonzero history");

  a_diff_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_beat && !vol_left_i[VOL_W-1] |->
      diff_left_i == ({1'b0, vol_left_i[BYTE_W-1:0]} - {1'b0, prev_vol_left_i}))
    else $error("left difference does not match volumes");

  a_not_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_beat |-> !(vol_left_i == '1 && vol_right_i == '1))
    else $error("note emitted for a fully dark pixel");

endmodule

bind pixel_column_to_note_records_top pcnr_checker u_pcnr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .record_kind_i   (out_if.record_kind),
  .row_or_count_i  (out_if.row_or_count),
  .vol_left_i      (out_if.vol_left),
  .prev_vol_left_i (out_if.prev_vol_left),
  .diff_left_i     (out_if.diff_left),
  .vol_right_i     (out_if.vol_right),
  .diff_right_i    (out_if.diff_right),
  .sample_index_i  (out_if.sample_index)
);

`default_nettype wire
